// ===== rtl/polynomial_distortion_correction_unit_defines.svh =====
// assertion helpers used by the distortion correction top module
`ifndef POLYNOMIAL_DISTORTION_CORRECTION_UNIT_DEFINES_SVH
`define POLYNOMIAL_DISTORTION_CORRECTION_UNIT_DEFINES_SVH

// property checked at every rising clock edge outside reset
`define PDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define PDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pdc_pkg.sv =====
`timescale 1ns / 1ps
package pdc_pkg;

  // request actions
  localparam logic [1:0] ACT_LOAD_X = 2'd0;
  localparam logic [1:0] ACT_LOAD_Y = 2'd1;
  localparam logic [1:0] ACT_EVAL   = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_FWD_MODE   = 3'd0;
  localparam logic [2:0] REG_POLY_ORDER = 3'd1;
  localparam logic [2:0] REG_DIST_SCALE = 3'd2;
  localparam logic [2:0] REG_REF_POINT  = 3'd3;
  localparam logic [2:0] REG_OFFSET     = 3'd4;
  localparam logic [2:0] REG_LT_SCALE   = 3'd5;
  localparam logic [2:0] REG_LT_SHIFT   = 3'd6;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  typedef struct packed {
    logic [1:0]         act;
    logic [4:0]         idx;
    logic signed [47:0] coef;
  } item_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [64:0] v);
    sat_t s;
    s.sat = 1'b0;
    s.val = v[31:0];
    if (v > 65'sd2147483647) begin
      s.sat = 1'b1;
      s.val = 32'sh7fff_ffff;
    end else if (v < -65'sd2147483648) begin
      s.sat = 1'b1;
      s.val = 32'sh8000_0000;
    end
    return s;
  endfunction

  // q16 product back to q16, round half up, clip
  function automatic sat_t rnd_sat16(input logic signed [63:0] p);
    logic signed [64:0] t;
    t = (65'(p) + 65'sd32768) >>> 16;
    return sat32(t);
  endfunction

endpackage

// ===== rtl/pdc_div.sv =====
`timescale 1ns / 1ps
module pdc_div #(
  parameter int NW = 49,
  parameter int DW = 32,
  parameter int TW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [NW-1:0] in_nx,
  input  logic signed [NW-1:0] in_ny,
  input  logic signed [DW-1:0] in_dx,
  input  logic signed [DW-1:0] in_dy,
  input  logic [TW-1:0]        in_tag,
  output logic                 out_vld,
  output logic signed [31:0]   out_qx,
  output logic signed [31:0]   out_qy,
  output logic                 out_sat,
  output logic [TW-1:0]        out_tag
);

  localparam logic [NW-1:0] POS_LIM = NW'(64'h7fff_ffff);
  localparam logic [NW-1:0] NEG_LIM = NW'(64'h8000_0000);

  logic signed [NW-1:0] n_in [2];
  logic signed [DW-1:0] d_in [2];
  assign n_in[0] = in_nx;
  assign n_in[1] = in_ny;
  assign d_in[0] = in_dx;
  assign d_in[1] = in_dy;

  logic          vld_r  [0:NW];
  logic [TW-1:0] tag_r  [0:NW];
  logic [NW-1:0] num_r  [2][0:NW];
  logic [DW-1:0] rem_r  [2][0:NW];
  logic [DW-1:0] den_r  [2][0:NW];
  logic          neg_r  [2][0:NW];
  logic          dz_r   [2][0:NW];
  logic          nneg_r [2][0:NW];
  logic          nz_r   [2][0:NW];

  // magnitudes and sign bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      tag_r[0] <= in_tag;
      for (int a = 0; a < 2; a++) begin
        num_r[a][0]  <= n_in[a][NW-1] ? NW'(-n_in[a]) : NW'(n_in[a]);
        den_r[a][0]  <= d_in[a][DW-1] ? DW'(-d_in[a]) : DW'(d_in[a]);
        rem_r[a][0]  <= '0;
        neg_r[a][0]  <= n_in[a][NW-1] ^ d_in[a][DW-1];
        dz_r[a][0]   <= (d_in[a] == '0);
        nneg_r[a][0] <= n_in[a][NW-1];
        nz_r[a][0]   <= (n_in[a] == '0);
      end
    end
  end

  // one restoring step per stage, quotient bits shift into num_r
  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0] trial [2];
    logic        ge    [2];

    always_comb begin
      for (int a = 0; a < 2; a++) begin
        trial[a] = {rem_r[a][k], num_r[a][k][NW-1]};
        ge[a]    = (trial[a] >= {1'b0, den_r[a][k]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
        tag_r[k+1] <= tag_r[k];
        for (int a = 0; a < 2; a++) begin
          num_r[a][k+1]  <= {num_r[a][k][NW-2:0], ge[a]};
          rem_r[a][k+1]  <= ge[a] ? DW'(trial[a] - {1'b0, den_r[a][k]}) : trial[a][DW-1:0];
          den_r[a][k+1]  <= den_r[a][k];
          neg_r[a][k+1]  <= neg_r[a][k];
          dz_r[a][k+1]   <= dz_r[a][k];
          nneg_r[a][k+1] <= nneg_r[a][k];
          nz_r[a][k+1]   <= nz_r[a][k];
        end
      end
    end
  end

  logic signed [31:0] q_nxt   [2];
  logic               sat_nxt [2];

  always_comb begin
    logic [NW-1:0] mag;
    mag = '0;
    for (int a = 0; a < 2; a++) begin
      mag        = num_r[a][NW];
      sat_nxt[a] = 1'b0;
      q_nxt[a]   = signed'(mag[31:0]);
      if (dz_r[a][NW]) begin
        sat_nxt[a] = 1'b1;
        if (nneg_r[a][NW]) begin
          q_nxt[a] = 32'sh8000_0000;
        end else if (nz_r[a][NW]) begin
          q_nxt[a] = '0;
        end else begin
          q_nxt[a] = 32'sh7fff_ffff;
        end
      end else if (neg_r[a][NW]) begin
        if (mag > NEG_LIM) begin
          sat_nxt[a] = 1'b1;
          q_nxt[a]   = 32'sh8000_0000;
        end else begin
          q_nxt[a] = -signed'(mag[31:0]);
        end
      end else if (mag > POS_LIM) begin
        sat_nxt[a] = 1'b1;
        q_nxt[a]   = 32'sh7fff_ffff;
      end
    end
  end

  logic               vo_r;
  logic signed [31:0] qx_r;
  logic signed [31:0] qy_r;
  logic               so_r;
  logic [TW-1:0]      to_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= vld_r[NW];
      to_r <= tag_r[NW];
      qx_r <= q_nxt[0];
      qy_r <= q_nxt[1];
      so_r <= sat_nxt[0] | sat_nxt[1];
    end
  end

  assign out_vld = vo_r;
  assign out_qx  = qx_r;
  assign out_qy  = qy_r;
  assign out_sat = so_r;
  assign out_tag = to_r;

endmodule

// ===== rtl/pdc_poly.sv =====
`timescale 1ns / 1ps
module pdc_poly import pdc_pkg::*; #(
  parameter int MAX_ORDER = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [2:0]         order,
  input  logic               in_vld,
  input  item_t              in_item,
  input  logic               in_sat,
  input  logic signed [31:0] in_rx,
  input  logic signed [31:0] in_ry,
  output logic               out_vld,
  output logic               out_sat,
  output logic signed [31:0] out_wx,
  output logic signed [31:0] out_wy
);

  localparam int D  = (MAX_ORDER + 1) * (MAX_ORDER + 2) / 2;
  localparam int NG = (D + 7) / 8;
  localparam int P  = 2 * MAX_ORDER - 2;

  logic  vld_r  [0:P+7];
  logic  sat_r  [0:P+7];
  item_t item_r [0:P+2];

  logic signed [31:0] pw_r [0:P][2][0:MAX_ORDER];
  logic signed [63:0] mp_r [0:P][2];

  // stage 0: x^0 and x^1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0]  <= in_vld;
      sat_r[0]  <= in_sat;
      item_r[0] <= in_item;
      for (int a = 0; a < 2; a++) begin
        for (int m = 0; m <= MAX_ORDER; m++) begin
          pw_r[0][a][m] <= '0;
        end
        pw_r[0][a][0] <= ONE_Q16;
      end
      pw_r[0][0][1] <= in_rx;
      pw_r[0][1][1] <= in_ry;
    end
  end

  // powers: multiply stage then round stage per degree
  for (genvar l = 2; l <= MAX_ORDER; l++) begin : g_pow
    localparam int SM = 2 * l - 3;
    localparam int SL = 2 * l - 2;
    sat_t rs [2];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[SM] <= 1'b0;
      end else if (en) begin
        vld_r[SM]  <= vld_r[SM-1];
        sat_r[SM]  <= sat_r[SM-1];
        item_r[SM] <= item_r[SM-1];
        pw_r[SM]   <= pw_r[SM-1];
        for (int a = 0; a < 2; a++) begin
          mp_r[SM][a] <= 64'(pw_r[SM-1][a][l-1]) * 64'(pw_r[SM-1][a][1]);
        end
      end
    end

    always_comb begin
      for (int a = 0; a < 2; a++) begin
        rs[a] = rnd_sat16(mp_r[SM][a]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[SL] <= 1'b0;
      end else if (en) begin
        vld_r[SL]  <= vld_r[SM];
        sat_r[SL]  <= sat_r[SM] | ((int'(order) >= l) & (rs[0].sat | rs[1].sat));
        item_r[SL] <= item_r[SM];
        pw_r[SL]   <= pw_r[SM];
        for (int a = 0; a < 2; a++) begin
          pw_r[SL][a][l] <= rs[a].val;
        end
      end
    end
  end

  // monomials x^j * y^(i-j), coefficient products and masked terms
  logic signed [63:0] mm_r [D];
  logic signed [31:0] m_r  [D];
  logic signed [47:0] xt_r [D];
  logic signed [47:0] yt_r [D];
  logic signed [55:0] ph_r [2][D];
  logic signed [56:0] pl_r [2][D];
  logic signed [47:0] tm_r [2][D];
  logic [D-1:0]       msat;

  for (genvar i = 0; i <= MAX_ORDER; i++) begin : g_row
    for (genvar j = 0; j <= i; j++) begin : g_col
      localparam int K = i * (i + 1) / 2 + j;
      sat_t                 ms;
      logic signed [47:0]   cf [2];
      logic signed [57:0]   t  [2];

      assign ms      = rnd_sat16(mm_r[K]);
      assign msat[K] = ms.sat & (int'(order) >= i);
      assign cf[0]   = xt_r[K];
      assign cf[1]   = yt_r[K];

      always_comb begin
        for (int a = 0; a < 2; a++) begin
          t[a] = 58'(ph_r[a][K]) + 58'(pl_r[a][K] >>> 24) + 58'sd32768;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          mm_r[K] <= 64'(pw_r[P][0][j]) * 64'(pw_r[P][1][i-j]);
          m_r[K]  <= ms.val;
          for (int a = 0; a < 2; a++) begin
            ph_r[a][K] <= 56'(signed'(cf[a][47:24])) * 56'(m_r[K]);
            pl_r[a][K] <= 57'(signed'({1'b0, cf[a][23:0]})) * 57'(m_r[K]);
            tm_r[a][K] <= (int'(order) >= i) ? 48'(t[a] >>> 16) : '0;
          end
        end
      end

      // table write happens where coefficients are read, so order is kept
      always_ff @(posedge clk) begin
        if (en && vld_r[P+2] && (K < 32) && (item_r[P+2].idx == 5'(K))) begin
          if (item_r[P+2].act == ACT_LOAD_X) begin
            xt_r[K] <= item_r[P+2].coef;
          end
          if (item_r[P+2].act == ACT_LOAD_Y) begin
            yt_r[K] <= item_r[P+2].coef;
          end
        end
      end
    end
  end

  logic signed [55:0] grp_r [2][NG];
  logic signed [55:0] grp_nxt [2][NG];
  logic signed [63:0] acc_r [2];
  logic signed [63:0] acc_nxt [2];
  sat_t               wsat [2];
  logic signed [31:0] wo_r [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      for (int g = 0; g < NG; g++) begin
        grp_nxt[a][g] = '0;
        for (int e = 0; e < 8; e++) begin
          if (8 * g + e < D) begin
            grp_nxt[a][g] = grp_nxt[a][g] + 56'(tm_r[a][8*g+e]);
          end
        end
      end
      acc_nxt[a] = '0;
      for (int g = 0; g < NG; g++) begin
        acc_nxt[a] = acc_nxt[a] + 64'(grp_r[a][g]);
      end
      wsat[a] = sat32(65'(acc_r[a]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = P + 1; s <= P + 7; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (en) begin
      vld_r[P+1]  <= vld_r[P];
      sat_r[P+1]  <= sat_r[P];
      item_r[P+1] <= item_r[P];
      vld_r[P+2]  <= vld_r[P+1];
      sat_r[P+2]  <= sat_r[P+1] | (|msat);
      item_r[P+2] <= item_r[P+1];
      // loads end at the table
      vld_r[P+3]  <= vld_r[P+2] && (item_r[P+2].act == ACT_EVAL);
      sat_r[P+3]  <= sat_r[P+2];
      for (int s = P + 4; s <= P + 6; s++) begin
        vld_r[s] <= vld_r[s-1];
        sat_r[s] <= sat_r[s-1];
      end
      vld_r[P+7] <= vld_r[P+6];
      sat_r[P+7] <= sat_r[P+6] | wsat[0].sat | wsat[1].sat;
      for (int a = 0; a < 2; a++) begin
        grp_r[a] <= grp_nxt[a];
        acc_r[a] <= acc_nxt[a];
        wo_r[a]  <= wsat[a].val;
      end
    end
  end

  assign out_vld = vld_r[P+7];
  assign out_sat = sat_r[P+7];
  assign out_wx  = wo_r[0];
  assign out_wy  = wo_r[1];

endmodule

// ===== rtl/polynomial_distortion_correction_unit.sv =====
// throughput: one request per cycle unless stalled; the two pipelined restoring dividers
//   (49 and 56 steps) and power/monomial stages all advance together under one stall enable
// coefficient loads flow down to the coefficient stage and write there, giving no result
// reset: synchronous active-low; clears valid bits and loads configuration defaults
`timescale 1ns / 1ps
`include "polynomial_distortion_correction_unit_defines.svh"
module polynomial_distortion_correction_unit import pdc_pkg::*; #(
  parameter int MAX_POLY_ORDER = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [4:0]         in_coeff_index,
  input  logic signed [47:0] in_coeff_value,
  input  logic signed [31:0] in_x_in,
  input  logic signed [31:0] in_y_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x_out,
  output logic signed [31:0] out_y_out,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  // ---------------- configuration registers ----------------
  logic        fwd_r;
  logic [2:0]  order_r;
  logic [31:0] dscale_r;
  logic [63:0] refp_r;
  logic [63:0] offs_r;
  logic [63:0] lts_r;
  logic [63:0] ltsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r    <= 1'b1;
      order_r  <= 3'd1;
      dscale_r <= 32'h0100_0000;
      refp_r   <= '0;
      offs_r   <= '0;
      lts_r    <= 64'h0001_0000_0001_0000;
      ltsh_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FWD_MODE:   fwd_r    <= cfg_data[0];
        REG_POLY_ORDER: order_r  <= cfg_data[2:0];
        REG_DIST_SCALE: dscale_r <= cfg_data[31:0];
        REG_REF_POINT:  refp_r   <= cfg_data;
        REG_OFFSET:     offs_r   <= cfg_data;
        REG_LT_SCALE:   lts_r    <= cfg_data;
        REG_LT_SHIFT:   ltsh_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-axis halves, x low and y high
  logic signed [31:0] refp  [2];
  logic signed [31:0] offs  [2];
  logic signed [31:0] lts   [2];
  logic signed [31:0] ltsh  [2];
  logic signed [32:0] dscale_s;

  assign refp[0] = signed'(refp_r[31:0]);
  assign refp[1] = signed'(refp_r[63:32]);
  assign offs[0] = signed'(offs_r[31:0]);
  assign offs[1] = signed'(offs_r[63:32]);
  assign lts[0]  = signed'(lts_r[31:0]);
  assign lts[1]  = signed'(lts_r[63:32]);
  assign ltsh[0] = signed'(ltsh_r[31:0]);
  assign ltsh[1] = signed'(ltsh_r[63:32]);
  assign dscale_s = signed'({1'b0, dscale_r});

  // ---------------- global stall ----------------
  // the pipe moves unless a finished result sits in the output register, is not
  // taken, and another result is right behind it
  logic en;
  logic e2_vld_r;
  logic ov_r;

  assign en       = out_ready || !ov_r || !e2_vld_r;
  assign in_ready = en;

  // ---------------- front: capture and (p - shift) << 16 ----------------
  logic               f0_vld_r;
  item_t              f0_item_r;
  logic signed [31:0] f0_p_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_vld_r <= 1'b0;
    end else if (en) begin
      // unknown action is accepted and dropped here
      f0_vld_r       <= in_valid && (in_action != ACT_NONE);
      f0_item_r.act  <= in_action;
      f0_item_r.idx  <= in_coeff_index;
      f0_item_r.coef <= in_coeff_value;
      f0_p_r[0]      <= in_x_in;
      f0_p_r[1]      <= in_y_in;
    end
  end

  logic               f1_vld_r;
  item_t              f1_item_r;
  logic signed [48:0] f1_n_r [2];
  logic signed [32:0] dif    [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      dif[a] = 33'(f0_p_r[a]) - 33'(ltsh[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r  <= f0_vld_r;
      f1_item_r <= f0_item_r;
      for (int a = 0; a < 2; a++) begin
        f1_n_r[a] <= {dif[a], 16'h0000};
      end
    end
  end

  // ---------------- inverse linear transform divider ----------------
  logic                     d1_vld;
  logic signed [31:0]       d1_qx;
  logic signed [31:0]       d1_qy;
  logic                     d1_sat;
  logic [$bits(item_t)-1:0] d1_tag;

  pdc_div #(
    .NW (49),
    .DW (32),
    .TW ($bits(item_t))
  ) u_div_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (f1_vld_r),
    .in_nx   (f1_n_r[0]),
    .in_ny   (f1_n_r[1]),
    .in_dx   (lts[0]),
    .in_dy   (lts[1]),
    .in_tag  (f1_item_r),
    .out_vld (d1_vld),
    .out_qx  (d1_qx),
    .out_qy  (d1_qy),
    .out_sat (d1_sat),
    .out_tag (d1_tag)
  );

  // ---------------- reference point, offset and scale (inverse mode) ----------------
  logic signed [31:0] d1_q [2];
  sat_t               ra   [2];
  sat_t               da   [2];

  assign d1_q[0] = d1_qx;
  assign d1_q[1] = d1_qy;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      ra[a] = sat32(65'(d1_q[a]) - 65'(refp[a]));
      da[a] = sat32(65'(ra[a].val) - 65'(offs[a]));
    end
  end

  logic               a_vld_r;
  logic               a_sat_r;
  item_t              a_item_r;
  logic signed [31:0] a_r_r [2];
  logic signed [31:0] a_d_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r  <= d1_vld;
      a_item_r <= item_t'(d1_tag);
      a_sat_r  <= d1_sat | ra[0].sat | ra[1].sat |
                  (!fwd_r & (da[0].sat | da[1].sat));
      for (int a = 0; a < 2; a++) begin
        a_r_r[a] <= ra[a].val;
        a_d_r[a] <= da[a].val;
      end
    end
  end

  logic               b_vld_r;
  logic               b_sat_r;
  item_t              b_item_r;
  logic signed [31:0] b_r_r    [2];
  logic signed [64:0] b_prod_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r  <= a_vld_r;
      b_sat_r  <= a_sat_r;
      b_item_r <= a_item_r;
      for (int a = 0; a < 2; a++) begin
        b_r_r[a]    <= a_r_r[a];
        b_prod_r[a] <= 65'(a_d_r[a]) * 65'(dscale_s);
      end
    end
  end

  // q8.24 scale product back to q16.16
  sat_t               cs [2];
  logic signed [31:0] u  [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      cs[a] = sat32((b_prod_r[a] + 65'sd8388608) >>> 24);
      u[a]  = fwd_r ? b_r_r[a] : cs[a].val;
    end
  end

  // ---------------- polynomial evaluation ----------------
  logic               p_vld;
  logic               p_sat;
  logic signed [31:0] p_wx;
  logic signed [31:0] p_wy;

  pdc_poly #(
    .MAX_ORDER (MAX_POLY_ORDER)
  ) u_poly (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .order   (order_r),
    .in_vld  (b_vld_r),
    .in_item (b_item_r),
    .in_sat  (b_sat_r | (!fwd_r & (cs[0].sat | cs[1].sat))),
    .in_rx   (u[0]),
    .in_ry   (u[1]),
    .out_vld (p_vld),
    .out_sat (p_sat),
    .out_wx  (p_wx),
    .out_wy  (p_wy)
  );

  // ---------------- forward mode divide by distortion scale ----------------
  // the polynomial sums ride in the tag so inverse mode can skip the quotient
  logic               d2_vld;
  logic signed [31:0] d2_qx;
  logic signed [31:0] d2_qy;
  logic               d2_sat;
  logic [64:0]        d2_tag;

  pdc_div #(
    .NW (56),
    .DW (33),
    .TW (65)
  ) u_div_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (p_vld),
    .in_nx   ({p_wx, 24'h000000}),
    .in_ny   ({p_wy, 24'h000000}),
    .in_dx   (dscale_s),
    .in_dy   (dscale_s),
    .in_tag  ({p_sat, p_wy, p_wx}),
    .out_vld (d2_vld),
    .out_qx  (d2_qx),
    .out_qy  (d2_qy),
    .out_sat (d2_sat),
    .out_tag (d2_tag)
  );

  // ---------------- offset, reference point, forward linear transform ----------------
  logic signed [31:0] d2_q [2];
  logic signed [31:0] d2_w [2];
  sat_t               ow   [2];
  logic signed [31:0] w1   [2];
  sat_t               w2   [2];

  assign d2_q[0] = d2_qx;
  assign d2_q[1] = d2_qy;
  assign d2_w[0] = signed'(d2_tag[31:0]);
  assign d2_w[1] = signed'(d2_tag[63:32]);

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      ow[a] = sat32(65'(d2_q[a]) + 65'(offs[a]));
      w1[a] = fwd_r ? ow[a].val : d2_w[a];
      w2[a] = sat32(65'(w1[a]) + 65'(refp[a]));
    end
  end

  logic               e1_vld_r;
  logic               e1_sat_r;
  logic signed [31:0] e1_w_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r <= 1'b0;
    end else if (en) begin
      e1_vld_r <= d2_vld;
      e1_sat_r <= d2_tag[64] | w2[0].sat | w2[1].sat |
                  (fwd_r & (d2_sat | ow[0].sat | ow[1].sat));
      for (int a = 0; a < 2; a++) begin
        e1_w_r[a] <= w2[a].val;
      end
    end
  end

  logic               e2_sat_r;
  logic signed [63:0] e2_prod_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e2_vld_r <= 1'b0;
    end else if (en) begin
      e2_vld_r <= e1_vld_r;
      e2_sat_r <= e1_sat_r;
      for (int a = 0; a < 2; a++) begin
        e2_prod_r[a] <= 64'(e1_w_r[a]) * 64'(lts[a]);
      end
    end
  end

  // rounded product is not clipped before the shift is added
  logic signed [64:0] w3  [2];
  sat_t               res [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      w3[a]  = (65'(e2_prod_r[a]) + 65'sd32768) >>> 16;
      res[a] = sat32(w3[a] + 65'(ltsh[a]));
    end
  end

  // ---------------- output register ----------------
  logic signed [31:0] ox_r;
  logic signed [31:0] oy_r;
  logic               os_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      if (ov_r && out_ready) begin
        ov_r <= 1'b0;
      end
      if (en && e2_vld_r) begin
        ov_r <= 1'b1;
        ox_r <= res[0].val;
        oy_r <= res[1].val;
        os_r <= e2_sat_r | res[0].sat | res[1].sat;
      end
    end
  end

  assign out_valid     = ov_r;
  assign out_x_out     = ox_r;
  assign out_y_out     = oy_r;
  assign out_saturated = os_r;

  // ---------------- checks ----------------
  `PDC_ASSERT(a_ready_when_empty, !ov_r |-> in_ready, "input stalled with empty output register")
  `PDC_ASSERT_NEXT(a_front_holds, !in_ready, $stable(f0_vld_r) && $stable(e2_vld_r), "pipeline moved during stall")
  `PDC_ASSERT(a_stall_cause, (e2_vld_r && !in_ready) |-> (ov_r && !out_ready), "stall without a waiting result")

endmodule

// ===== sim/tb_polynomial_distortion_correction_unit.sv =====
`timescale 1ns / 1ps
module tb_polynomial_distortion_correction_unit;
  import pdc_pkg::*;

  // pipeline depth at the default order, plus margin for drain waits
  localparam int PIPE_LATENCY = 2 * 5 + 122;
  localparam int DRAIN_WAIT   = PIPE_LATENCY + 20;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int TABLE_SIZE   = 21;
  localparam int ORDER_CAP    = 5;
  localparam int SEGMENTS     = 8;
  localparam int SEG_ITEMS    = 144;
  localparam int HOLD_CYCLES  = 4000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_action;
  logic [4:0]         in_coeff_index;
  logic signed [47:0] in_coeff_value;
  logic signed [31:0] in_x_in;
  logic signed [31:0] in_y_in;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_x_out;
  logic signed [31:0] out_y_out;
  logic               out_saturated;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [63:0]        cfg_data;

  polynomial_distortion_correction_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_coeff_index(in_coeff_index),
    .in_coeff_value(in_coeff_value), .in_x_in(in_x_in), .in_y_in(in_y_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x_out(out_x_out), .out_y_out(out_y_out), .out_saturated(out_saturated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // one mapped point as the block should deliver it
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               sat;
  } mapped_point_t;

  // one directed request, with an optional typed-in answer
  typedef struct {
    logic [1:0]         act;
    logic [4:0]         idx;
    logic signed [47:0] coef;
    logic signed [31:0] x;
    logic signed [31:0] y;
    bit                 typed;
    mapped_point_t      ans;
  } directed_row_t;

  mapped_point_t pending_points[$];
  directed_row_t directed_rows[$];
  int            error_count;
  int            cycle_count;

  // idle percentages per side, changed between phases
  int snd_idle_pct;
  int rcv_idle_pct;
  // receiver hold-off requests, served by the receiver process
  int hold_requests;
  int hold_served;
  int hold_left;

  // shadow configuration and coefficient tables
  logic        sh_fwd;
  logic [2:0]  sh_order;
  logic [31:0] sh_dscale;
  logic [63:0] sh_ref;
  logic [63:0] sh_off;
  logic [63:0] sh_lts;
  logic [63:0] sh_ltsh;
  longint      sh_xtab[TABLE_SIZE];
  longint      sh_ytab[TABLE_SIZE];
  bit          clip_hit;

  // ---------------------------------------------------------------
  // predictor arithmetic, all in 64-bit signed
  // ---------------------------------------------------------------
  function automatic longint half_of(input logic [63:0] r, input int a);
    logic signed [31:0] h;
    h = (a != 0) ? r[63:32] : r[31:0];
    return h;
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) begin
      clip_hit = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clip_hit = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // truncating divide; zero divisor gives the signed extreme (zero for a zero numerator) and flags
  function automatic longint safe_div(input longint n, input longint d);
    if (d == 0) begin
      clip_hit = 1'b1;
      if (n > 0) return 64'sd2147483647;
      if (n < 0) return -64'sd2147483648;
      return 0;
    end
    return clip32(n / d);
  endfunction

  function automatic longint q16_mul(input longint a, input longint b);
    return clip32((a * b + 64'sd32768) >>> 16);
  endfunction

  // q8.40 coefficient times q16.16 monomial, split to stay exact
  function automatic longint coef_times(input longint c, input longint m);
    longint hi;
    longint lo;
    longint t;
    hi = c >>> 24;
    lo = c & 64'sh0000_0000_00FF_FFFF;
    t  = hi * m + ((lo * m) >>> 24);
    return (t + 64'sd32768) >>> 16;
  endfunction

  function automatic mapped_point_t map_point(input logic signed [31:0] xi,
                                              input logic signed [31:0] yi);
    longint        p[2];
    longint        pw[2][ORDER_CAP+1];
    longint        acc[2];
    longint        res[2];
    longint        r;
    longint        d;
    longint        w;
    longint        dscale;
    longint        m;
    int            ord;
    int            k;
    mapped_point_t mp;
    clip_hit = 1'b0;
    p[0] = xi;
    p[1] = yi;
    acc[0] = 0;
    acc[1] = 0;
    dscale = longint'({32'd0, sh_dscale});
    ord = (sh_order > ORDER_CAP) ? ORDER_CAP : int'(sh_order);
    for (int a = 0; a < 2; a++) begin
      // inverse linear transform, then relative to the reference point
      r = safe_div((p[a] - half_of(sh_ltsh, a)) * 64'sd65536, half_of(sh_lts, a));
      r = clip32(r - half_of(sh_ref, a));
      if (!sh_fwd) begin
        d = clip32(r - half_of(sh_off, a));
        r = clip32((d * dscale + 64'sd8388608) >>> 24);
      end
      pw[a][0] = 64'sd65536;
      for (int i = 1; i <= ord; i++) pw[a][i] = q16_mul(pw[a][i-1], r);
    end
    for (int i = 0; i <= ord; i++) begin
      for (int j = 0; j <= i; j++) begin
        k = i * (i + 1) / 2 + j;
        m = q16_mul(pw[0][j], pw[1][i-j]);
        acc[0] += coef_times(sh_xtab[k], m);
        acc[1] += coef_times(sh_ytab[k], m);
      end
    end
    for (int a = 0; a < 2; a++) begin
      w = clip32(acc[a]);
      if (sh_fwd) begin
        w = safe_div(w * 64'sd16777216, dscale);
        w = clip32(w + half_of(sh_off, a));
      end
      w = clip32(w + half_of(sh_ref, a));
      w = (w * half_of(sh_lts, a) + 64'sd32768) >>> 16;
      res[a] = clip32(w + half_of(sh_ltsh, a));
    end
    mp.x = res[0][31:0];
    mp.y = res[1][31:0];
    mp.sat = clip_hit;
    return mp;
  endfunction

  // ---------------------------------------------------------------
  // clock, reset, watchdog
  // ---------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // receiver: random ready, plus long hold-offs on request
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      // start a hold-off counted here, sender keeps pushing
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // results are checked at the falling edge, where both sides are stable,
  // and are taken by the block at the next rising edge
  always @(negedge clk) begin
    mapped_point_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        $error("result with no request waiting: x_out=%0d y_out=%0d", out_x_out, out_y_out);
        error_count++;
      end else begin
        want = pending_points.pop_front();
        if (out_x_out !== want.x) begin
          $error("x_out expected %0d actual %0d", want.x, out_x_out);
          error_count++;
        end
        if (out_y_out !== want.y) begin
          $error("y_out expected %0d actual %0d", want.y, out_y_out);
          error_count++;
        end
        if (out_saturated !== want.sat) begin
          $error("saturated expected %0d actual %0d", want.sat, out_saturated);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------
  // offer one request, wait for it to be taken, then update the shadow state
  task automatic offer_request(input logic [1:0] act, input logic [4:0] idx,
                               input logic signed [47:0] coef,
                               input logic signed [31:0] x, input logic signed [31:0] y,
                               input bit typed, input mapped_point_t ans);
    bit taken;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_coeff_index <= idx;
    in_coeff_value <= coef;
    in_x_in        <= x;
    in_y_in        <= y;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    if ((act == ACT_LOAD_X) && (idx < TABLE_SIZE)) sh_xtab[idx] = coef;
    if ((act == ACT_LOAD_Y) && (idx < TABLE_SIZE)) sh_ytab[idx] = coef;
    if (act == ACT_EVAL) pending_points.push_back(typed ? ans : map_point(x, y));
  endtask

  task automatic offer_predicted(input logic [1:0] act, input logic [4:0] idx,
                                 input logic signed [47:0] coef,
                                 input logic signed [31:0] x, input logic signed [31:0] y);
    mapped_point_t none;
    none = '{x: 0, y: 0, sat: 0};
    offer_request(act, idx, coef, x, y, 1'b0, none);
  endtask

  // drain the pipe, then let loads still in flight settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_FWD_MODE:   sh_fwd    = val[0];
      REG_POLY_ORDER: sh_order  = val[2:0];
      REG_DIST_SCALE: sh_dscale = val[31:0];
      REG_REF_POINT:  sh_ref    = val;
      REG_OFFSET:     sh_off    = val;
      REG_LT_SCALE:   sh_lts    = val;
      REG_LT_SHIFT:   sh_ltsh   = val;
      default: ;
    endcase
  endtask

  // signed value spread over +/- 2^(bits-1)
  function automatic logic [31:0] rand_span(input int bits);
    logic [31:0] v;
    v = $urandom;
    v = v & ((32'd1 << bits) - 1);
    return v - (32'd1 << (bits - 1));
  endfunction

  // plausible linear transform scale, 0.25 .. 2.0, either sign
  function automatic logic [31:0] rand_lt_half();
    logic [31:0] s;
    s = $urandom_range(131072, 16384);
    return $urandom_range(1) ? -s : s;
  endfunction

  task automatic apply_segment_config(input int seg);
    logic        fwd;
    logic [2:0]  ord;
    logic [31:0] dsc;
    logic [63:0] ref_v;
    logic [63:0] off_v;
    logic [63:0] lts_v;
    logic [63:0] sh_v;
    fwd   = 1'b1;
    ord   = 3'd1;
    dsc   = 32'h0100_0000;
    ref_v = {rand_span(22), rand_span(22)};
    off_v = {rand_span(18), rand_span(18)};
    lts_v = {rand_lt_half(), rand_lt_half()};
    sh_v  = {rand_span(24), rand_span(24)};
    case (seg)
      0: begin
        lts_v = {32'h0001_0000, 32'h0001_0000};
        sh_v  = 64'd0;
      end
      1: begin
        fwd = 1'b0;
        ord = 3'd5;
        dsc = 32'hFFFF_FFFF;
      end
      2: begin
        ord = 3'd7;   // above the maximum, treated as the maximum
        dsc = 32'd1;
      end
      3: begin
        fwd = 1'b0;
        ord = 3'd0;
        dsc = $urandom;
        ref_v = 64'hFFFF_FFFF_FFFF_FFFF;
        off_v = 64'h8000_0000_7FFF_FFFF;
      end
      4: begin
        // zero divisors for the distortion scale and the x-axis linear transform scale
        ord = 3'd3;
        dsc = 32'd0;
        lts_v = {rand_lt_half(), 32'd0};
      end
      5: begin
        ord = 3'd5;
        dsc = $urandom_range(32'h0400_0000, 32'h0040_0000);
      end
      6: begin
        fwd = 1'b0;
        ord = 3'd2;
        dsc = $urandom_range(32'h0200_0000, 32'h0080_0000);
        lts_v = {32'h7FFF_FFFF, 32'h8000_0000};
        sh_v  = {32'h8000_0000, 32'h7FFF_FFFF};
      end
      default: begin
        ord = 3'd4;
      end
    endcase
    wait_idle();
    write_reg(REG_FWD_MODE,   {63'd0, fwd});
    write_reg(REG_POLY_ORDER, {61'd0, ord});
    write_reg(REG_DIST_SCALE, {32'd0, dsc});
    write_reg(REG_REF_POINT,  ref_v);
    write_reg(REG_OFFSET,     off_v);
    write_reg(REG_LT_SCALE,   lts_v);
    write_reg(REG_LT_SHIFT,   sh_v);
  endtask

  task automatic offer_random_request();
    int                 pick;
    logic [1:0]         act;
    logic [4:0]         idx;
    logic signed [47:0] coef;
    logic signed [31:0] x;
    logic signed [31:0] y;
    pick = $urandom_range(99);
    if (pick < 65) begin
      act = ACT_EVAL;
      idx = $urandom;
    end else if (pick < 90) begin
      act = $urandom_range(1) ? ACT_LOAD_Y : ACT_LOAD_X;
      idx = $urandom_range(TABLE_SIZE - 1);
    end else if (pick < 95) begin
      // index past the table, ignored
      act = $urandom_range(1) ? ACT_LOAD_Y : ACT_LOAD_X;
      idx = $urandom_range(31, TABLE_SIZE);
    end else begin
      act = ACT_NONE;
      idx = $urandom;
    end
    if ($urandom_range(3) == 0) coef = {$urandom, $urandom};
    else coef = 48'(signed'({$urandom, $urandom} <<< 22) >>> 22);
    x = ($urandom_range(3) == 0) ? $urandom : rand_span(21);
    y = ($urandom_range(3) == 0) ? $urandom : rand_span(21);
    offer_predicted(act, idx, coef, x, y);
  endtask

  function automatic void add_row(input logic [1:0] act, input logic [4:0] idx,
                                  input logic signed [47:0] coef,
                                  input logic signed [31:0] x, input logic signed [31:0] y,
                                  input bit typed);
    directed_row_t row;
    row.act = act;
    row.idx = idx;
    row.coef = coef;
    row.x = x;
    row.y = y;
    row.typed = typed;
    // with identity tables and reset settings a point maps onto itself
    row.ans = '{x: x, y: y, sat: 1'b0};
    directed_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------
  initial begin
    mapped_point_t none;
    none = '{x: 0, y: 0, sat: 0};
    error_count    = 0;
    cycle_count    = 0;
    hold_requests  = 0;
    hold_served    = 0;
    hold_left      = 0;
    snd_idle_pct   = 7;
    rcv_idle_pct   = 86;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = ACT_NONE;
    in_coeff_index = '0;
    in_coeff_value = '0;
    in_x_in        = '0;
    in_y_in        = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_FWD_MODE;
    cfg_data       = '0;
    // shadow of the reset settings
    sh_fwd    = 1'b1;
    sh_order  = 3'd1;
    sh_dscale = 32'h0100_0000;
    sh_ref    = 64'd0;
    sh_off    = 64'd0;
    sh_lts    = {32'h0001_0000, 32'h0001_0000};
    sh_ltsh   = 64'd0;
    foreach (sh_xtab[k]) begin
      sh_xtab[k] = 0;
      sh_ytab[k] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill both tables: x = x, y = y, every other term zero
    for (int k = 0; k < TABLE_SIZE; k++) begin
      offer_predicted(ACT_LOAD_X, k, (k == 2) ? 48'sh0100_0000_0000 : 48'sd0, 0, 0);
      offer_predicted(ACT_LOAD_Y, k, (k == 1) ? 48'sh0100_0000_0000 : 48'sd0, 0, 0);
    end

    // directed part, under reset settings
    add_row(ACT_EVAL,   5'd0,  48'sd0, 32'sd0, 32'sd0, 1'b1);
    add_row(ACT_EVAL,   5'd31, 48'sh7FFF_FFFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    add_row(ACT_EVAL,   5'd0,  48'sh8000_0000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
    add_row(ACT_EVAL,   5'd17, 48'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    add_row(ACT_EVAL,   5'd0,  48'sd0, 32'sd1, -32'sd1, 1'b1);
    // loads past the table and the unused action change nothing
    add_row(ACT_LOAD_X, 5'd21, 48'sh7FFF_FFFF_FFFF, 32'sd0, 32'sd0, 1'b0);
    add_row(ACT_LOAD_Y, 5'd31, 48'sh7FFF_FFFF_FFFF, 32'sd0, 32'sd0, 1'b0);
    add_row(ACT_NONE,   5'd0,  48'sh7FFF_FFFF_FFFF, 32'sd5, 32'sd5, 1'b0);
    add_row(ACT_EVAL,   5'd0,  48'sd0, 32'sd12345, -32'sd6789, 1'b1);
    // extreme constant terms
    add_row(ACT_LOAD_X, 5'd0,  48'sh7FFF_FFFF_FFFF, 32'sd0, 32'sd0, 1'b0);
    add_row(ACT_LOAD_Y, 5'd0,  48'sh8000_0000_0000, 32'sd0, 32'sd0, 1'b0);
    add_row(ACT_EVAL,   5'd0,  48'sd0, 32'sd65536, -32'sd131072, 1'b0);
    add_row(ACT_EVAL,   5'd0,  48'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    add_row(ACT_LOAD_X, 5'd0,  48'sd0, 32'sd0, 32'sd0, 1'b0);
    add_row(ACT_LOAD_Y, 5'd0,  48'sd0, 32'sd0, 32'sd0, 1'b0);
    add_row(ACT_EVAL,   5'd0,  48'sd0, 32'sd3000000, 32'sd42, 1'b1);
    foreach (directed_rows[r]) begin
      offer_request(directed_rows[r].act, directed_rows[r].idx, directed_rows[r].coef,
                    directed_rows[r].x, directed_rows[r].y,
                    directed_rows[r].typed, directed_rows[r].ans);
    end

    // random part, one setting per segment
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      apply_segment_config(seg);
      if (seg >= 6) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end else if (seg >= 3) begin
        snd_idle_pct = 86;
        rcv_idle_pct = 7;
      end
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // long receiver hold-off so the pipe backs up into the input
        if ((seg == 6) && (n == 20)) hold_requests++;
        // sender pause until every result is back
        if ((seg == 7) && (n == 60)) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_points.size() != 0) @(posedge clk);
        end
        offer_random_request();
      end
    end

    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
